@@ design/rv64sc_pkg.sv @@
// Shared types, decode constants and the instruction decoder for the RV64I-subset core.
// Used by every module under design/; has no dependencies of its own.
`timescale 1ns / 1ps

package rv64sc_pkg;

    localparam int unsigned REGISTER_COUNT   = 32;
    localparam int unsigned REG_IDX_W        = 5;
    localparam int unsigned XLEN             = 64;
    localparam int unsigned MAX_INSTRUCTIONS = 1024;
    localparam int unsigned ICOUNT_W         = 11;
    localparam int unsigned OUT_TDATA_W      = 112;

    localparam logic [6:0] OPC_REG    = 7'h33;
    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_OR  = 3'd6;
    localparam logic [2:0] F3_AND = 3'd7;

    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_ILLEGAL = 2'd1;
    localparam logic [1:0] FAULT_RANGE   = 2'd2;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_SLL,
        OP_AND,
        OP_OR,
        OP_LD,
        OP_SD,
        OP_BEQ,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op  op;
        logic use_imm;
    } t_dec;

    // Register file write request.
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [XLEN-1:0]      data;
    } t_rf_wr;

    // Data memory access controls.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_dmem_ctl;

    function automatic t_op alu_op(input logic [2:0] f3);
        t_op op;
        begin
            unique case (f3)
                F3_ADD:  op = OP_ADD;
                F3_SLL:  op = OP_SLL;
                F3_OR:   op = OP_OR;
                F3_AND:  op = OP_AND;
                default: op = OP_BAD;
            endcase
            return op;
        end
    endfunction

    function automatic t_dec decode(input logic [31:0] w);
        t_dec       d;
        logic [6:0] opc;
        logic [6:0] f7;
        logic [2:0] f3;
        begin
            opc       = w[6:0];
            f7        = w[31:25];
            f3        = w[14:12];
            d.op      = OP_BAD;
            d.use_imm = 1'b0;
            unique case (opc)
                OPC_REG: begin
                    if (f7 == F7_BASE) begin
                        d.op = alu_op(f3);
                    end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                        d.op = OP_SUB;
                    end
                end
                OPC_IMM: begin
                    // The upper immediate bits play no part in choosing the operation.
                    d.op      = alu_op(f3);
                    d.use_imm = 1'b1;
                end
                OPC_LOAD:   d.op = OP_LD;
                OPC_STORE:  d.op = OP_SD;
                OPC_BRANCH: d.op = OP_BEQ;
                default:    d.op = OP_BAD;
            endcase
            return d;
        end
    endfunction

endpackage

@@ design/rv64_subset_single_cycle_core.sv @@
// Top level of the RV64I-subset core: pipeline control, execute logic and result register.
// Depends on rv64sc_pkg, rv64sc_regfile and rv64sc_dmem.
//
// Usage: the caller presents each instruction word, fetched at the pc reported by the
// previous result, on the s_axis request channel. Each accepted word yields exactly one
// result on m_axis: the next pc, whether the program is still running, the register
// write, the store flag and a fault code. instruction_count is written through
// i_cfg_we / i_cfg_wdata while no instruction is in flight.
// Pipeline: an accepted word is registered together with its register file read, then
// executed along with the data memory access, and the writeback stage then loads the
// result register.
// Throughput: one instruction per cycle while not stalled. A word that reads the
// destination of the load directly ahead of it waits for the load data.
// Reset: pc, register file and configuration return to their reset values at once;
// the data memory is then cleared one 8-byte row per cycle, and s_axis_tready stays
// low until that has finished.
// Stall: while m_axis_tready is low the result register holds, the two pipeline
// stages fill and then s_axis_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module rv64_subset_single_cycle_core #(
    parameter int unsigned DATA_BYTES = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [rv64sc_pkg::ICOUNT_W-1:0]        i_cfg_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [31:0] instruction_word
    input  logic [31:0]                            s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [31:0] next_pc, [32] running, [33] write_enable, [38:34] dest_register,
    // [102:39] write_value, [103] store_done, [105:104] fault, [111:106] zero
    output logic [rv64sc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int unsigned ADDR_W = $clog2(DATA_BYTES);
    localparam logic [63:0] ADDR_MAX = 64'(DATA_BYTES - 8);

    // Control state.
    logic                              r_s1_valid;
    logic                              r_s2_valid;
    logic                              r_out_valid;
    logic [31:0]                       r_pc;
    logic [rv64sc_pkg::ICOUNT_W-1:0]   r_icount;
    logic                              r_snp_a_vld;
    logic                              r_snp_b_vld;
    logic                              n_snp_a_vld;
    logic                              n_snp_b_vld;

    // Payload.
    logic [31:0]                       r_s1_word;
    logic [63:0]                       r_snp_a;
    logic [63:0]                       r_snp_b;
    logic [63:0]                       n_snp_a;
    logic [63:0]                       n_snp_b;
    logic [31:0]                       r_s2_next;
    logic                              r_s2_wr;
    logic [rv64sc_pkg::REG_IDX_W-1:0]  r_s2_rd;
    logic [63:0]                       r_s2_alu;
    logic                              r_s2_is_ld;
    logic                              r_s2_st;
    logic [1:0]                        r_s2_fault;
    logic [rv64sc_pkg::OUT_TDATA_W-1:0] r_out_data;

    // Handshake and pipeline control.
    logic accept;
    logic out_load;
    logic s2_adv;
    logic s2_free;
    logic s1_adv;
    logic s1_free;
    logic hazard;
    logic clearing;

    // Execute stage signals.
    rv64sc_pkg::t_dec                  dec;
    logic [rv64sc_pkg::REG_IDX_W-1:0]  rs1;
    logic [rv64sc_pkg::REG_IDX_W-1:0]  rs2;
    logic [rv64sc_pkg::REG_IDX_W-1:0]  rd;
    logic [63:0]                       rf_a;
    logic [63:0]                       rf_b;
    logic [63:0]                       op_a;
    logic [63:0]                       op_b;
    logic [63:0]                       imm_i;
    logic [63:0]                       imm_s;
    logic [31:0]                       imm_b;
    logic [63:0]                       op_y;
    logic [63:0]                       alu_res;
    logic [63:0]                       addr;
    logic                              in_range;
    logic                              is_alu;
    logic                              s1_wr;
    logic                              s1_st;
    logic [1:0]                        s1_fault;
    logic [31:0]                       s1_next;

    // Writeback stage signals.
    logic [63:0]                       ld_data;
    logic [63:0]                       s2_val;
    logic [63:0]                       wr_val;
    logic                              running;
    rv64sc_pkg::t_rf_wr                rf_wr;
    rv64sc_pkg::t_dmem_ctl             dm_ctl;

    assign out_load = !r_out_valid || m_axis_tready;
    assign s2_adv   = r_s2_valid && out_load;
    assign s2_free  = !r_s2_valid || s2_adv;

    assign rs1 = r_s1_word[19:15];
    assign rs2 = r_s1_word[24:20];
    assign rd  = r_s1_word[11:7];

    // Load data is only ready in the writeback stage, so a dependant waits while the load is there.
    assign hazard = r_s2_valid && r_s2_is_ld && r_s2_wr
                    && (r_s2_rd == rs1 || r_s2_rd == rs2);
    assign s1_adv  = r_s1_valid && s2_free && !hazard;
    assign s1_free = !r_s1_valid || s1_adv;

    assign s_axis_tready = s1_free && !clearing;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign rf_wr.en   = s2_adv && r_s2_wr;
    assign rf_wr.addr = r_s2_rd;
    assign rf_wr.data = s2_val;

    rv64sc_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_addr_a (s_axis_tdata[19:15]),
        .i_rd_addr_b (s_axis_tdata[24:20]),
        .i_wr        (rf_wr),
        .o_rd_data_a (rf_a),
        .o_rd_data_b (rf_b)
    );

    // Operand selection: the instruction in writeback is newest, then any write that
    // landed after the register file was read.
    always_comb begin
        if (r_s2_valid && r_s2_wr && !r_s2_is_ld && r_s2_rd == rs1) begin
            op_a = r_s2_alu;
        end else if (r_snp_a_vld) begin
            op_a = r_snp_a;
        end else begin
            op_a = rf_a;
        end
        if (r_s2_valid && r_s2_wr && !r_s2_is_ld && r_s2_rd == rs2) begin
            op_b = r_s2_alu;
        end else if (r_snp_b_vld) begin
            op_b = r_snp_b;
        end else begin
            op_b = rf_b;
        end
    end

    always_comb begin
        n_snp_a_vld = r_snp_a_vld;
        n_snp_b_vld = r_snp_b_vld;
        n_snp_a     = r_snp_a;
        n_snp_b     = r_snp_b;
        if (accept) begin
            n_snp_a_vld = rf_wr.en && rf_wr.addr == s_axis_tdata[19:15];
            n_snp_b_vld = rf_wr.en && rf_wr.addr == s_axis_tdata[24:20];
            n_snp_a     = rf_wr.data;
            n_snp_b     = rf_wr.data;
        end else begin
            if (rf_wr.en && rf_wr.addr == rs1) begin
                n_snp_a_vld = 1'b1;
                n_snp_a     = rf_wr.data;
            end
            if (rf_wr.en && rf_wr.addr == rs2) begin
                n_snp_b_vld = 1'b1;
                n_snp_b     = rf_wr.data;
            end
        end
    end

    assign dec   = rv64sc_pkg::decode(r_s1_word);
    assign imm_i = {{52{r_s1_word[31]}}, r_s1_word[31:20]};
    assign imm_s = {{52{r_s1_word[31]}}, r_s1_word[31:25], r_s1_word[11:7]};
    assign imm_b = {{19{r_s1_word[31]}}, r_s1_word[31], r_s1_word[7],
                    r_s1_word[30:25], r_s1_word[11:8], 1'b0};
    assign op_y  = dec.use_imm ? imm_i : op_b;

    always_comb begin
        unique case (dec.op)
            rv64sc_pkg::OP_ADD: alu_res = op_a + op_y;
            rv64sc_pkg::OP_SUB: alu_res = op_a - op_y;
            rv64sc_pkg::OP_SLL: alu_res = op_a << op_y[5:0];
            rv64sc_pkg::OP_AND: alu_res = op_a & op_y;
            rv64sc_pkg::OP_OR:  alu_res = op_a | op_y;
            default:            alu_res = '0;
        endcase
    end

    assign is_alu = dec.op == rv64sc_pkg::OP_ADD || dec.op == rv64sc_pkg::OP_SUB
                    || dec.op == rv64sc_pkg::OP_SLL || dec.op == rv64sc_pkg::OP_AND
                    || dec.op == rv64sc_pkg::OP_OR;

    assign addr     = op_a + ((dec.op == rv64sc_pkg::OP_SD) ? imm_s : imm_i);
    assign in_range = addr <= ADDR_MAX;

    assign s1_wr = (is_alu || (dec.op == rv64sc_pkg::OP_LD && in_range)) && rd != '0;
    assign s1_st = dec.op == rv64sc_pkg::OP_SD && in_range;

    always_comb begin
        if (dec.op == rv64sc_pkg::OP_BAD) begin
            s1_fault = rv64sc_pkg::FAULT_ILLEGAL;
        end else if ((dec.op == rv64sc_pkg::OP_LD || dec.op == rv64sc_pkg::OP_SD)
                     && !in_range) begin
            s1_fault = rv64sc_pkg::FAULT_RANGE;
        end else begin
            s1_fault = rv64sc_pkg::FAULT_NONE;
        end
    end

    assign s1_next = (dec.op == rv64sc_pkg::OP_BEQ && op_a == op_b) ? r_pc + imm_b
                                                                    : r_pc + 32'd4;

    assign dm_ctl.rd_en = s1_adv && dec.op == rv64sc_pkg::OP_LD;
    assign dm_ctl.wr_en = s1_adv && s1_st;

    rv64sc_dmem #(
        .DATA_BYTES (DATA_BYTES)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dm_ctl),
        .i_addr  (addr[ADDR_W-1:0]),
        .i_wdata (op_b),
        .o_rdata (ld_data),
        .o_busy  (clearing)
    );

    assign s2_val  = r_s2_is_ld ? ld_data : r_s2_alu;
    assign wr_val  = r_s2_wr ? s2_val : '0;
    assign running = ({2'b00, r_s2_next[31:2]} < 32'(r_icount))
                     && ({2'b00, r_s2_next[31:2]} < 32'(rv64sc_pkg::MAX_INSTRUCTIONS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_icount    <= rv64sc_pkg::ICOUNT_W'(1);
            r_snp_a_vld <= 1'b0;
            r_snp_b_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_icount <= i_cfg_wdata;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
                r_pc       <= s1_next;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_snp_a_vld <= n_snp_a_vld;
            r_snp_b_vld <= n_snp_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_snp_a <= n_snp_a;
        r_snp_b <= n_snp_b;
        if (accept) begin
            r_s1_word <= s_axis_tdata;
        end
        if (s1_adv) begin
            r_s2_next  <= s1_next;
            r_s2_wr    <= s1_wr;
            r_s2_rd    <= s1_wr ? rd : '0;
            r_s2_alu   <= alu_res;
            r_s2_is_ld <= dec.op == rv64sc_pkg::OP_LD;
            r_s2_st    <= s1_st;
            r_s2_fault <= s1_fault;
        end
        if (s2_adv) begin
            r_out_data <= {6'b000000, r_s2_fault, r_s2_st, wr_val, r_s2_rd,
                           r_s2_wr, running, r_s2_next};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ design/rv64sc_regfile.sv @@
// 32 x 64-bit register file: one write port, two registered read ports.
// Depends on rv64sc_pkg. Entries never written (and x0) read as zero via valid bits.
`timescale 1ns / 1ps

module rv64sc_regfile (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [rv64sc_pkg::REG_IDX_W-1:0] i_rd_addr_a,
    input  logic [rv64sc_pkg::REG_IDX_W-1:0] i_rd_addr_b,
    input  rv64sc_pkg::t_rf_wr              i_wr,
    output logic [rv64sc_pkg::XLEN-1:0]     o_rd_data_a,
    output logic [rv64sc_pkg::XLEN-1:0]     o_rd_data_b
);

    logic [rv64sc_pkg::XLEN-1:0]           r_mem [rv64sc_pkg::REGISTER_COUNT];
    logic [rv64sc_pkg::REGISTER_COUNT-1:0] r_valid;
    logic [rv64sc_pkg::XLEN-1:0]           r_rd_a;
    logic [rv64sc_pkg::XLEN-1:0]           r_rd_b;
    logic                                  r_rd_a_vld;
    logic                                  r_rd_b_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_a_vld <= 1'b0;
            r_rd_b_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_a_vld <= r_valid[i_rd_addr_a];
                r_rd_b_vld <= r_valid[i_rd_addr_b];
            end
        end
    end

    assign o_rd_data_a = r_rd_a_vld ? r_rd_a : '0;
    assign o_rd_data_b = r_rd_b_vld ? r_rd_b : '0;

endmodule

@@ design/rv64sc_dmem.sv @@
// Byte-addressed data memory built from eight byte-wide banks, one per address lane.
// Depends on rv64sc_pkg. Handles unaligned 8-byte little-endian reads and writes,
// and clears itself one row per cycle after reset.
`timescale 1ns / 1ps

module rv64sc_dmem #(
    parameter int unsigned DATA_BYTES = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rv64sc_pkg::t_dmem_ctl           i_ctl,
    input  logic [$clog2(DATA_BYTES)-1:0]   i_addr,
    input  logic [rv64sc_pkg::XLEN-1:0]     i_wdata,
    output logic [rv64sc_pkg::XLEN-1:0]     o_rdata,
    output logic                            o_busy
);

    localparam int unsigned ADDR_W = $clog2(DATA_BYTES);
    localparam int unsigned ROWS   = (DATA_BYTES + 7) / 8;
    localparam int unsigned ROW_W  = ADDR_W - 3;

    logic             r_busy;
    logic [ROW_W-1:0] r_clr_row;
    logic [2:0]       r_off;
    logic [63:0]      bank_q;
    logic [127:0]     wr_rot;
    logic [127:0]     rd_rot;

    // Lane b takes the byte whose offset from the access address is (b - offset) mod 8.
    assign wr_rot = {i_wdata, i_wdata} << {i_addr[2:0], 3'b000};

    for (genvar b = 0; b < 8; b++) begin : g_bank
        logic [7:0]        r_mem [ROWS];
        logic [7:0]        r_q;
        logic [ADDR_W-1:0] lane_sum;
        logic [ROW_W-1:0]  row;

        assign lane_sum = i_addr + ADDR_W'(7 - b);
        assign row      = lane_sum[ADDR_W-1:3];

        always_ff @(posedge i_clk) begin
            if (r_busy) begin
                r_mem[r_clr_row] <= 8'h00;
            end else if (i_ctl.wr_en) begin
                r_mem[row] <= wr_rot[64 + 8*b +: 8];
            end
            if (i_ctl.rd_en) begin
                r_q <= r_mem[row];
            end
        end

        assign bank_q[8*b +: 8] = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_off <= i_addr[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_row <= '0;
        end else if (r_busy) begin
            if (r_clr_row == ROW_W'(ROWS - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_row <= r_clr_row + 1'b1;
        end
    end

    assign rd_rot  = {bank_q, bank_q} >> {r_off, 3'b000};
    assign o_rdata = rd_rot[63:0];
    assign o_busy  = r_busy;

endmodule
